FILE: rtl/wpsp_pkg.sv
// shared types and constants for the wav pcm stream parser
`timescale 1ns / 1ps

package wpsp_pkg;

  // little-endian header tags as they sit in the shift register
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam int unsigned HEADER_BYTES = 44;
  localparam int unsigned RIFF_BIAS    = 8;
  localparam int unsigned FLEN_W       = 31;
  localparam logic [FLEN_W-1:0] FLEN_RESET = FLEN_W'(HEADER_BYTES);

  localparam logic [31:0] FMT_SIZE    = 32'd16;
  localparam logic [15:0] FMT_PCM     = 16'd1;
  localparam logic [15:0] MONO        = 16'd1;
  localparam logic [31:0] RATE_HZ     = 32'd16000;
  localparam logic [31:0] RATE_PER_BYTE_BIT = RATE_HZ / 32'd8;

  localparam logic [15:0] WIDTH_8  = 16'd8;
  localparam logic [15:0] WIDTH_16 = 16'd16;
  localparam logic [15:0] WIDTH_32 = 16'd32;

  // byte offsets at which a header field is complete
  localparam logic [5:0] POS_RIFF_TAG  = 6'd3;
  localparam logic [5:0] POS_RIFF_SIZE = 6'd7;
  localparam logic [5:0] POS_WAVE_TAG  = 6'd11;
  localparam logic [5:0] POS_FMT_TAG   = 6'd15;
  localparam logic [5:0] POS_FMT_SIZE  = 6'd19;
  localparam logic [5:0] POS_FORMAT    = 6'd21;
  localparam logic [5:0] POS_CHANNELS  = 6'd23;
  localparam logic [5:0] POS_RATE      = 6'd27;
  localparam logic [5:0] POS_BYTE_RATE = 6'd31;
  localparam logic [5:0] POS_ALIGN     = 6'd33;
  localparam logic [5:0] POS_BITS      = 6'd35;
  localparam logic [5:0] POS_DATA_TAG  = 6'd39;
  localparam logic [5:0] POS_DATA_SIZE = 6'd43;

  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_RIFF_TAG    = 4'd1,
    ST_RIFF_SIZE   = 4'd2,
    ST_WAVE_TAG    = 4'd3,
    ST_FMT_TAG     = 4'd4,
    ST_FMT_SIZE    = 4'd5,
    ST_FORMAT      = 4'd6,
    ST_CHANNELS    = 4'd7,
    ST_RATE        = 4'd8,
    ST_BYTE_RATE   = 4'd9,
    ST_BLOCK_ALIGN = 4'd10,
    ST_DATA_TAG    = 4'd11,
    ST_DATA_SIZE   = 4'd12,
    ST_BITS        = 4'd13,
    ST_LENGTH      = 4'd14
  } status_t;

  typedef struct packed {
    logic [31:0] sample;
    logic        sample_valid;
    logic        finished;
    status_t     status;
  } result_t;

endpackage

FILE: rtl/wpsp_ifs.sv
// channel interfaces of the wav pcm stream parser
`timescale 1ns / 1ps

interface wpsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;
  modport source (output valid, byte_value, last_byte, input ready);
  modport sink (input valid, byte_value, last_byte, output ready);
endinterface

interface wpsp_out_if;
  logic                signed [31:0] sample;
  logic                valid;
  logic                ready;
  logic                sample_valid;
  logic                finished;
  wpsp_pkg::status_t   status;
  modport source (output valid, sample, sample_valid, finished, status, input ready);
  modport sink (input valid, sample, sample_valid, finished, status, output ready);
endinterface

interface wpsp_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [wpsp_pkg::FLEN_W-1:0]       file_length;
  modport source (output valid, file_length, input ready);
  modport sink (input valid, file_length, output ready);
endinterface

FILE: rtl/wav_pcm_stream_parser_unit.sv
// wav pcm stream parser: header checks and sample assembly, one byte per cycle while the skid register is free
`timescale 1ns / 1ps

//  channel  dir  payload                                  request taken when
//  in_if    in   byte_value[7:0], last_byte               valid & ready
//  out_if   out  sample[31:0], sample_valid, finished,    valid & ready
//                status[3:0]
//  cfg_if   in   file_length[30:0]                        valid & ready (ready tied high)
//
//  one byte per cycle sustained; a byte enters an input register and is parsed
//  from there once the skid register is free; its result (if any) is registered
//  into the output register. bytes that produce no result leave nothing behind.
//  a stalled result parks in a skid register, so one more byte is still taken;
//  input stalls only while the skid register is occupied.
//  reset clears all parse state and sets file_length to 44.

module wav_pcm_stream_parser_unit (
  input  logic             clk,
  input  logic             rst_n,
  wpsp_in_if.sink          in_if,
  wpsp_out_if.source       out_if,
  wpsp_cfg_if.sink         cfg_if
);

  // input stage
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       s1_adv;
  logic       in_fire;

  // parse state
  logic [wpsp_pkg::FLEN_W-1:0] flen_r;
  logic [31:0]       pos_r, pos_nxt;
  logic [31:0]       shift_r, shift_nxt;
  logic [31:0]       brate_r, brate_nxt;
  logic [15:0]       balign_r, balign_nxt;
  logic [15:0]       width_r, width_nxt;
  logic [1:0]        sidx_r, sidx_nxt;
  wpsp_pkg::status_t err_r, err_nxt;

  // output register and skid
  wpsp_pkg::result_t o_r, sk_r, res;
  logic              o_valid_r, sk_valid_r;
  logic              has_res, push, pop;

  // parse datapath
  logic [31:0]       shift_new;
  logic [15:0]       hw;
  logic [31:0]       bits_ext;
  logic [31:0]       brate_exp;
  logic [15:0]       align_exp;
  logic              pos_in_len, in_hdr, smp_done;
  logic [31:0]       smp;
  wpsp_pkg::status_t new_err;

  assign cfg_if.ready = 1'b1;
  assign s1_adv       = s1_valid_r && !sk_valid_r;
  assign in_if.ready  = !s1_valid_r || s1_adv;
  assign in_fire      = in_if.valid && in_if.ready;

  always_comb begin
    shift_new  = {s1_byte_r, shift_r[31:8]};
    hw         = shift_new[31:16];
    bits_ext   = {{16{hw[15]}}, hw};
    brate_exp  = bits_ext * wpsp_pkg::RATE_PER_BYTE_BIT;
    // signed divide by 8 rounding toward zero
    align_exp  = {{3{hw[15]}}, hw[15:3]};
    if (hw[15] && (hw[2:0] != 3'd0)) begin
      align_exp = align_exp + 16'd1;
    end
    pos_in_len = pos_r < {1'b0, flen_r};
    in_hdr     = pos_r < 32'(wpsp_pkg::HEADER_BYTES);

    pos_nxt    = (pos_r != '1) ? pos_r + 32'd1 : pos_r;
    shift_nxt  = shift_r;
    brate_nxt  = brate_r;
    balign_nxt = balign_r;
    width_nxt  = width_r;
    sidx_nxt   = sidx_r;
    err_nxt    = err_r;
    new_err    = wpsp_pkg::ST_OK;
    smp_done   = 1'b0;
    smp        = shift_new;

    if (err_r == wpsp_pkg::ST_OK) begin
      if (!pos_in_len) begin
        new_err = wpsp_pkg::ST_LENGTH;
      end else begin
        shift_nxt = shift_new;
        if (in_hdr) begin
          unique case (pos_r[5:0])
            wpsp_pkg::POS_RIFF_TAG: begin
              if (shift_new != wpsp_pkg::TAG_RIFF) new_err = wpsp_pkg::ST_RIFF_TAG;
            end
            wpsp_pkg::POS_RIFF_SIZE: begin
              if (shift_new != {1'b0, flen_r - wpsp_pkg::FLEN_W'(wpsp_pkg::RIFF_BIAS)})
                new_err = wpsp_pkg::ST_RIFF_SIZE;
            end
            wpsp_pkg::POS_WAVE_TAG: begin
              if (shift_new != wpsp_pkg::TAG_WAVE) new_err = wpsp_pkg::ST_WAVE_TAG;
            end
            wpsp_pkg::POS_FMT_TAG: begin
              if (shift_new != wpsp_pkg::TAG_FMT) new_err = wpsp_pkg::ST_FMT_TAG;
            end
            wpsp_pkg::POS_FMT_SIZE: begin
              if (shift_new != wpsp_pkg::FMT_SIZE) new_err = wpsp_pkg::ST_FMT_SIZE;
            end
            wpsp_pkg::POS_FORMAT: begin
              if (hw != wpsp_pkg::FMT_PCM) new_err = wpsp_pkg::ST_FORMAT;
            end
            wpsp_pkg::POS_CHANNELS: begin
              if (hw != wpsp_pkg::MONO) new_err = wpsp_pkg::ST_CHANNELS;
            end
            wpsp_pkg::POS_RATE: begin
              if (shift_new != wpsp_pkg::RATE_HZ) new_err = wpsp_pkg::ST_RATE;
            end
            wpsp_pkg::POS_BYTE_RATE: begin
              brate_nxt = shift_new;
            end
            wpsp_pkg::POS_ALIGN: begin
              balign_nxt = hw;
            end
            wpsp_pkg::POS_BITS: begin
              width_nxt = hw;
              if (brate_r != brate_exp) begin
                new_err = wpsp_pkg::ST_BYTE_RATE;
              end else if (balign_r != align_exp) begin
                new_err = wpsp_pkg::ST_BLOCK_ALIGN;
              end
            end
            wpsp_pkg::POS_DATA_TAG: begin
              if (shift_new != wpsp_pkg::TAG_DATA) new_err = wpsp_pkg::ST_DATA_TAG;
            end
            wpsp_pkg::POS_DATA_SIZE: begin
              if (shift_new != {1'b0, flen_r - wpsp_pkg::FLEN_W'(wpsp_pkg::HEADER_BYTES)}) begin
                new_err = wpsp_pkg::ST_DATA_SIZE;
              end else if ((width_r != wpsp_pkg::WIDTH_8) && (width_r != wpsp_pkg::WIDTH_16) &&
                           (width_r != wpsp_pkg::WIDTH_32)) begin
                new_err = wpsp_pkg::ST_BITS;
              end
            end
            default: begin
            end
          endcase
        end else begin
          // data bytes: width is 8, 16 or 32 once the header has passed
          case (width_r)
            wpsp_pkg::WIDTH_8: begin
              smp_done = 1'b1;
              smp      = {{24{shift_new[31]}}, shift_new[31:24]};
            end
            wpsp_pkg::WIDTH_16: begin
              smp_done = (sidx_r != 2'd0);
              smp      = {{16{shift_new[31]}}, shift_new[31:16]};
            end
            default: begin
              smp_done = (sidx_r == 2'd3);
              smp      = shift_new;
            end
          endcase
          sidx_nxt = smp_done ? 2'd0 : sidx_r + 2'd1;
        end
        if ((new_err == wpsp_pkg::ST_OK) && s1_last_r &&
            ((pos_r + 32'd1 != {1'b0, flen_r}) ||
             (pos_r < 32'(wpsp_pkg::HEADER_BYTES - 1)) || (sidx_nxt != 2'd0))) begin
          new_err = wpsp_pkg::ST_LENGTH;
        end
      end
      err_nxt = new_err;
    end

    res.sample       = smp_done ? smp : 32'd0;
    res.sample_valid = smp_done;
    res.finished     = s1_last_r;
    res.status       = new_err;
    has_res          = smp_done || (new_err != wpsp_pkg::ST_OK) || s1_last_r;

    // end of file: back to a clean slate for the next one
    if (s1_last_r) begin
      pos_nxt    = '0;
      shift_nxt  = '0;
      brate_nxt  = '0;
      balign_nxt = '0;
      width_nxt  = '0;
      sidx_nxt   = '0;
      err_nxt    = wpsp_pkg::ST_OK;
    end
  end

  assign push = s1_adv && has_res;
  assign pop  = o_valid_r && out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      o_valid_r  <= 1'b0;
      sk_valid_r <= 1'b0;
      flen_r     <= wpsp_pkg::FLEN_RESET;
      pos_r      <= '0;
      shift_r    <= '0;
      brate_r    <= '0;
      balign_r   <= '0;
      width_r    <= '0;
      sidx_r     <= '0;
      err_r      <= wpsp_pkg::ST_OK;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (cfg_if.valid && cfg_if.ready) begin
        flen_r <= cfg_if.file_length;
      end
      if (s1_adv) begin
        pos_r    <= pos_nxt;
        shift_r  <= shift_nxt;
        brate_r  <= brate_nxt;
        balign_r <= balign_nxt;
        width_r  <= width_nxt;
        sidx_r   <= sidx_nxt;
        err_r    <= err_nxt;
      end
      if (sk_valid_r) begin
        if (pop) begin
          sk_valid_r <= 1'b0;
        end
      end else if (push) begin
        if (o_valid_r && !pop) begin
          sk_valid_r <= 1'b1;
        end else begin
          o_valid_r <= 1'b1;
        end
      end else if (pop) begin
        o_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_if.byte_value;
      s1_last_r <= in_if.last_byte;
    end
    if (sk_valid_r) begin
      if (pop) begin
        o_r <= sk_r;
      end
    end else if (push) begin
      if (o_valid_r && !pop) begin
        sk_r <= res;
      end else begin
        o_r <= res;
      end
    end
  end

  assign out_if.valid        = o_valid_r;
  assign out_if.sample       = $signed(o_r.sample);
  assign out_if.sample_valid = o_r.sample_valid;
  assign out_if.finished     = o_r.finished;
  assign out_if.status       = o_r.status;

  // skid only ever holds a result behind an occupied output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    sk_valid_r |-> o_valid_r)
    else $error("skid register full while output register empty");

  // the last byte of a file leaves a clean parse state
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_last_r) |=> (pos_r == 32'd0) && (err_r == wpsp_pkg::ST_OK) &&
                              (sidx_r == 2'd0))
    else $error("parse state not cleared after last byte");

  // a recorded error holds until the file ends
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ((err_r != wpsp_pkg::ST_OK) && !(s1_adv && s1_last_r)) |=> $stable(err_r))
    else $error("sticky error changed before end of file");

  // samples come only from data bytes of a clean file
  a_sample_in_data: assert property (@(posedge clk) disable iff (!rst_n)
    (push && res.sample_valid) |->
      (pos_r >= 32'(wpsp_pkg::HEADER_BYTES)) && (err_r == wpsp_pkg::ST_OK))
    else $error("sample produced outside the data section");

endmodule

FILE: tb/wav_pcm_stream_parser_unit_tb.sv
// self-checking testbench for the wav pcm stream parser: header checks, samples, length rules
`timescale 1ns / 1ps

module wav_pcm_stream_parser_unit_tb;
  import wpsp_pkg::*;

  localparam int CYCLE_LIMIT = 300_000;

  logic clk;
  logic rst_n;
  bit   steady;
  int   err_count = 0;
  int   cycle_count = 0;
  int   bytes_sent;
  bit   cfg_written;

  wpsp_in_if  in_ch();
  wpsp_out_if out_ch();
  wpsp_cfg_if cfg_ch();

  wav_pcm_stream_parser_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // parser state as the block should hold it
  logic [FLEN_W-1:0] file_len;
  logic [31:0]       byte_pos;
  logic [31:0]       field_word;
  logic [31:0]       stored_rate;
  logic [15:0]       stored_align;
  logic [15:0]       sample_bits;
  logic [1:0]        sample_lane;
  status_t           sticky_err;

  result_t    parsed_results[$];
  logic [7:0] file_bytes[$];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    err_count++;
  endtask

  function automatic void clear_file_state();
    byte_pos     = '0;
    field_word   = '0;
    stored_rate  = '0;
    stored_align = '0;
    sample_bits  = '0;
    sample_lane  = '0;
    sticky_err   = ST_OK;
  endfunction

  // advance the parser by one byte; returns 1 when the byte yields a result
  function automatic bit parse_byte(input logic [7:0] value, input logic last,
                                    output result_t r);
    logic [31:0] pos;
    logic [31:0] w;
    logic [31:0] sample_word;
    status_t     fresh;
    bit          got;
    int          bits;
    int          align;
    pos         = byte_pos;
    fresh       = ST_OK;
    got         = 1'b0;
    sample_word = '0;
    if (sticky_err == ST_OK) begin
      if (pos >= {1'b0, file_len}) begin
        fresh = ST_LENGTH;
      end else begin
        field_word = {value, field_word[31:8]};
        w = field_word;
        if (pos < HEADER_BYTES) begin
          case (pos[5:0])
            POS_RIFF_TAG:  if (w != TAG_RIFF) fresh = ST_RIFF_TAG;
            POS_RIFF_SIZE: begin
              if (longint'($signed(w)) != longint'(file_len) - longint'(RIFF_BIAS))
                fresh = ST_RIFF_SIZE;
            end
            POS_WAVE_TAG:  if (w != TAG_WAVE) fresh = ST_WAVE_TAG;
            POS_FMT_TAG:   if (w != TAG_FMT) fresh = ST_FMT_TAG;
            POS_FMT_SIZE:  if (w != FMT_SIZE) fresh = ST_FMT_SIZE;
            POS_FORMAT:    if (w[31:16] != FMT_PCM) fresh = ST_FORMAT;
            POS_CHANNELS:  if (w[31:16] != MONO) fresh = ST_CHANNELS;
            POS_RATE:      if (w != RATE_HZ) fresh = ST_RATE;
            POS_BYTE_RATE: stored_rate = w;
            POS_ALIGN:     stored_align = w[31:16];
            POS_BITS: begin
              sample_bits = w[31:16];
              bits  = int'($signed(w[31:16]));
              align = int'($signed(stored_align));
              if (longint'($signed(stored_rate)) != longint'(bits) * longint'(RATE_PER_BYTE_BIT))
                fresh = ST_BYTE_RATE;
              else if (align != bits / 8)
                fresh = ST_BLOCK_ALIGN;
            end
            POS_DATA_TAG:  if (w != TAG_DATA) fresh = ST_DATA_TAG;
            POS_DATA_SIZE: begin
              if (longint'($signed(w)) != longint'(file_len) - longint'(HEADER_BYTES))
                fresh = ST_DATA_SIZE;
              else if (sample_bits != WIDTH_8 && sample_bits != WIDTH_16 &&
                       sample_bits != WIDTH_32)
                fresh = ST_BITS;
            end
            default: ;
          endcase
        end else begin
          // only 8, 16 or 32 bits get past the header
          if (int'(sample_lane) + 1 >= int'(sample_bits) / 8) begin
            case (sample_bits)
              WIDTH_8:  sample_word = {{24{w[31]}}, w[31:24]};
              WIDTH_16: sample_word = {{16{w[31]}}, w[31:16]};
              default:  sample_word = w;
            endcase
            got = 1'b1;
            sample_lane = '0;
          end else begin
            sample_lane = sample_lane + 2'd1;
          end
        end
        if (fresh == ST_OK && last &&
            (pos + 32'd1 != {1'b0, file_len} || pos < HEADER_BYTES - 1 || sample_lane != 0))
          fresh = ST_LENGTH;
      end
      sticky_err = fresh;
    end
    if (byte_pos != '1) byte_pos = byte_pos + 32'd1;
    r.sample       = got ? sample_word : '0;
    r.sample_valid = got;
    r.finished     = last;
    r.status       = fresh;
    if (last) clear_file_state();
    return got || fresh != ST_OK || last;
  endfunction

  function automatic void append_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) file_bytes.push_back(v[8*i +: 8]);
  endfunction

  // fills file_bytes with a 44-byte header; a flaw in a header field corrupts one byte of it.
  // returns the position of the last byte of the flawed field, or 43 when no field is corrupted
  function automatic int build_header(input logic [FLEN_W-1:0] len, input logic [15:0] bits,
                                      input status_t flaw);
    int lo;
    int n;
    int k;
    logic [15:0] align;
    align = 16'(int'($signed(bits)) / 8);
    file_bytes.delete();
    append_le(TAG_RIFF, 4);
    append_le(32'(len) - RIFF_BIAS, 4);
    append_le(TAG_WAVE, 4);
    append_le(TAG_FMT, 4);
    append_le(FMT_SIZE, 4);
    append_le(32'(FMT_PCM), 2);
    append_le(32'(MONO), 2);
    append_le(RATE_HZ, 4);
    append_le({{16{bits[15]}}, bits} * RATE_PER_BYTE_BIT, 4);
    append_le(32'(align), 2);
    append_le(32'(bits), 2);
    append_le(TAG_DATA, 4);
    append_le(32'(len) - HEADER_BYTES, 4);
    lo = 0;
    case (flaw)
      ST_RIFF_TAG:    n = 4;
      ST_RIFF_SIZE:   begin lo = 4;  n = 4; end
      ST_WAVE_TAG:    begin lo = 8;  n = 4; end
      ST_FMT_TAG:     begin lo = 12; n = 4; end
      ST_FMT_SIZE:    begin lo = 16; n = 4; end
      ST_FORMAT:      begin lo = 20; n = 2; end
      ST_CHANNELS:    begin lo = 22; n = 2; end
      ST_RATE:        begin lo = 24; n = 4; end
      ST_BYTE_RATE:   begin lo = 28; n = 4; end
      ST_BLOCK_ALIGN: begin lo = 32; n = 2; end
      ST_DATA_TAG:    begin lo = 36; n = 4; end
      ST_DATA_SIZE:   begin lo = 40; n = 4; end
      default:        n = 0;
    endcase
    if (n > 0) begin
      k = $urandom_range(n - 1);
      file_bytes[lo + k] = file_bytes[lo + k] ^ 8'($urandom_range(1, 255));
      return lo + n - 1;
    end
    return HEADER_BYTES - 1;
  endfunction

  // called at a falling edge; returns at the falling edge after the request is taken
  task automatic send_byte(input logic [7:0] value, input logic last);
    result_t r;
    while (!steady && $urandom_range(99) < 31) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.byte_value <= value;
    in_ch.last_byte  <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
    if (parse_byte(value, last, r)) parsed_results.push_back(r);
    @(negedge clk);
  endtask

  // bytes beyond the built file are random
  task automatic send_file(input int count);
    for (int i = 0; i < count; i++)
      send_byte(i < file_bytes.size() ? file_bytes[i] : 8'($urandom), i == count - 1);
  endtask

  // every file ends with a last byte, which always yields a result
  task automatic drain_parser();
    in_ch.valid <= 1'b0;
    while (parsed_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_file_length(input logic [FLEN_W-1:0] v);
    if (!cfg_written || v != file_len) begin
      drain_parser();
      cfg_ch.valid       <= 1'b1;
      cfg_ch.file_length <= v;
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
      file_len    = v;
      cfg_written = 1'b1;
      @(negedge clk);
      cfg_ch.valid <= 1'b0;
    end
  endtask

  task automatic test_clean_files();
    set_file_length(44);
    void'(build_header(44, WIDTH_16, ST_OK));
    send_file(44);
    set_file_length(48);
    void'(build_header(48, WIDTH_8, ST_OK));
    append_le(32'h80FF_7F00, 4);
    send_file(48);
    set_file_length(52);
    void'(build_header(52, WIDTH_16, ST_OK));
    append_le(32'h7FFF_8000, 4);
    append_le(32'hFFFF_0000, 4);
    send_file(52);
    void'(build_header(52, WIDTH_32, ST_OK));
    append_le(32'h8000_0000, 4);
    append_le(32'h7FFF_FFFF, 4);
    send_file(52);
  endtask

  task automatic test_header_flaws();
    status_t flaw;
    int      last_pos;
    set_file_length(48);
    for (int k = ST_RIFF_TAG; k <= ST_BITS; k++) begin
      flaw = status_t'(k);
      // 24 bits keeps byte rate and align consistent but is not supported
      last_pos = build_header(48, flaw == ST_BITS ? 16'd24 : WIDTH_16, flaw);
      append_le($urandom, 4);
      send_file(last_pos + 2 < 48 ? last_pos + 2 : 48);
    end
  endtask

  task automatic test_length_rules();
    // bytes past the declared length
    set_file_length(44);
    void'(build_header(44, WIDTH_8, ST_OK));
    send_file(46);
    // last byte inside the header
    send_file(20);
    // odd byte left over from a 16-bit sample
    set_file_length(47);
    void'(build_header(47, WIDTH_16, ST_OK));
    send_file(47);
    // premature last byte that still completes a sample
    set_file_length(50);
    void'(build_header(50, WIDTH_16, ST_OK));
    send_file(46);
  endtask

  task automatic test_length_extremes();
    set_file_length('0);
    file_bytes.delete();
    send_file(3);
    set_file_length(8);
    void'(build_header(8, WIDTH_16, ST_OK));
    send_file(12);
    // huge file cut short after two samples
    set_file_length('1);
    void'(build_header('1, WIDTH_32, ST_OK));
    send_file(52);
  endtask

  task automatic test_random_files(input int n_bytes);
    int                start_at;
    int                kind;
    int                data_bytes;
    int                count;
    int                last_pos;
    logic [15:0]       bits;
    logic [FLEN_W-1:0] len;
    status_t           flaw;
    start_at = bytes_sent;
    while (bytes_sent < start_at + n_bytes) begin
      kind = $urandom_range(99);
      if (kind >= 92) begin
        // raw noise under a random length
        if ($urandom_range(1)) len = FLEN_W'($urandom);
        else len = FLEN_W'($urandom_range(64));
        set_file_length(len);
        file_bytes.delete();
        send_file($urandom_range(1, 40));
      end else begin
        if (kind >= 84) begin
          do bits = 16'($urandom);
          while (bits == WIDTH_8 || bits == WIDTH_16 || bits == WIDTH_32);
          data_bytes = $urandom_range(8);
        end else begin
          case ($urandom_range(2))
            0:       bits = WIDTH_8;
            1:       bits = WIDTH_16;
            default: bits = WIDTH_32;
          endcase
          data_bytes = $urandom_range(10) * (int'(bits) / 8);
        end
        flaw = (kind >= 65 && kind < 75) ?
               status_t'($urandom_range(ST_RIFF_TAG, ST_DATA_SIZE)) : ST_OK;
        len = FLEN_W'(HEADER_BYTES + data_bytes);
        set_file_length(len);
        last_pos = build_header(len, bits, flaw);
        repeat (data_bytes) file_bytes.push_back(8'($urandom));
        count = int'(len);
        if (kind >= 75 && kind < 84) begin
          if ($urandom_range(1)) count = $urandom_range(1, int'(len));
          else count = int'(len) + $urandom_range(1, 4);
        end else if (flaw != ST_OK && $urandom_range(1)) begin
          count = last_pos + 1 + $urandom_range(3);
        end
        send_file(count);
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= steady || ($urandom_range(99) >= 31);
    end
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (parsed_results.size() == 0) begin
        report_mismatch("result with nothing pending");
      end else begin
        want = parsed_results.pop_front();
        if (out_ch.sample !== want.sample)
          report_mismatch($sformatf("sample %h, want %h", out_ch.sample, want.sample));
        if (out_ch.sample_valid !== want.sample_valid)
          report_mismatch($sformatf("sample_valid %b, want %b", out_ch.sample_valid,
                                    want.sample_valid));
        if (out_ch.finished !== want.finished)
          report_mismatch($sformatf("finished %b, want %b", out_ch.finished, want.finished));
        if (out_ch.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_ch.status, want.status));
      end
    end
  end

  initial begin
    rst_n              = 1'b0;
    steady             = 1'b0;
    bytes_sent         = 0;
    cfg_written        = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.byte_value   = '0;
    in_ch.last_byte    = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.file_length = FLEN_RESET;
    file_len           = FLEN_RESET;
    clear_file_state();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // clean files run with no idling on either side
    steady = 1'b1;
    test_clean_files();
    steady = 1'b0;
    test_header_flaws();
    test_length_rules();
    test_length_extremes();
    test_random_files(60);
    drain_parser();
    repeat (8) @(negedge clk);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/wpsp_pkg.sv
rtl/wpsp_ifs.sv
rtl/wav_pcm_stream_parser_unit.sv
tb/wav_pcm_stream_parser_unit_tb.sv
